>>> hdl/hrfw_pkg.sv
// Package for the hex record to flash write converter.
// Holds the shared constants, the result word type and the hex digit decoder.
// No dependencies.
package hrfw_pkg;

  localparam int unsigned CharWidth  = 8;
  localparam int unsigned AddrWidth  = 32;
  localparam int unsigned DataWidth  = 16;
  localparam int unsigned PosWidth   = 10;
  localparam int unsigned IndexWidth = 7;
  localparam int unsigned AccWidth   = 16;

  localparam logic [PosWidth-1:0]  PosIdle      = 10'd1023;
  localparam logic [PosWidth-1:0]  PosCountEnd  = 10'd2;
  localparam logic [PosWidth-1:0]  PosAddrEnd   = 10'd6;
  localparam logic [PosWidth-1:0]  PosKind      = 10'd8;
  localparam logic [PosWidth-1:0]  PosFirstWord = 10'd12;

  localparam logic [AddrWidth-1:0] BaseReset = 32'h0800_0000;

  localparam logic [CharWidth-1:0] CharColon   = 8'h3A;
  localparam logic [CharWidth-1:0] CharZero    = 8'd48;
  localparam logic [CharWidth-1:0] CharNine    = 8'd57;
  localparam logic [CharWidth-1:0] LetterBias  = 8'd55;
  localparam logic [CharWidth-1:0] KindData    = 8'h30;
  localparam logic [CharWidth-1:0] KindUpper   = 8'h34;

  typedef struct packed {
    logic                 last_of_record;
    logic [DataWidth-1:0] write_data;
    logic [AddrWidth-1:0] write_address;
  } result_t;

  // Decimal digits subtract the code of zero; anything else is treated as a letter.
  function automatic logic [3:0] hex_value(input logic [CharWidth-1:0] c);
    logic [CharWidth-1:0] v;
    if (c >= CharZero && c <= CharNine) begin
      v = c - CharZero;
    end else begin
      v = c - LetterBias;
    end
    return v[3:0];
  endfunction

endpackage

>>> hdl/hrfw_parser.sv
// Record parser: character position, field capture and halfword write generation.
// Depends on hrfw_pkg.
module hrfw_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [hrfw_pkg::CharWidth-1:0] char_i,
  output logic                          result_valid_o,
  output hrfw_pkg::result_t             result_o
);
  import hrfw_pkg::*;

  logic [PosWidth-1:0]   pos_q, pos_d, pos_next;
  logic [7:0]            count_q, count_d;
  logic [15:0]           low_q, low_d;
  logic [CharWidth-1:0]  kind_q, kind_d;
  logic [AddrWidth-1:0]  base_q, base_d;
  logic [AccWidth-1:0]   acc_q, acc_d;
  logic [IndexWidth-1:0] idx_q, idx_d;
  logic [IndexWidth-1:0] pairs;

  assign pairs = count_q[7:1];

  always_comb begin
    pos_d          = pos_q;
    count_d        = count_q;
    low_d          = low_q;
    kind_d         = kind_q;
    base_d         = base_q;
    acc_d          = acc_q;
    idx_d          = idx_q;
    pos_next       = pos_q + 1'b1;
    result_valid_o = 1'b0;
    result_o       = '0;
    if (accept_i) begin
      if (char_i == CharColon) begin
        pos_d = '0;
        acc_d = '0;
        idx_d = '0;
      end else if (pos_q != PosIdle) begin
        pos_d = pos_next;
        if (pos_next != PosIdle) begin
          acc_d = {acc_q[AccWidth-5:0], hex_value(char_i)};
          if (pos_next == PosCountEnd) begin
            count_d = acc_d[7:0];
          end else if (pos_next == PosAddrEnd) begin
            low_d = acc_d;
          end else if (pos_next == PosKind) begin
            kind_d = char_i;
            if (char_i == KindData) begin
              base_d = {base_q[31:16], low_q};
            end
          end else if (pos_next >= PosFirstWord && pos_next[1:0] == 2'b00) begin
            if (kind_q == KindUpper && pos_next == PosFirstWord) begin
              base_d = {acc_d, base_q[15:0]};
            end else if (kind_q == KindData && idx_q < pairs) begin
              result_valid_o          = 1'b1;
              result_o.write_address  = base_q + {{(AddrWidth-IndexWidth-1){1'b0}}, idx_q, 1'b0};
              result_o.write_data     = {acc_d[7:0], acc_d[15:8]};
              result_o.last_of_record = ({1'b0, idx_q} + 8'd1) == {1'b0, pairs};
              idx_d                   = idx_q + 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= PosIdle;
      count_q <= '0;
      low_q   <= '0;
      kind_q  <= '0;
      base_q  <= BaseReset;
      acc_q   <= '0;
      idx_q   <= '0;
    end else begin
      pos_q   <= pos_d;
      count_q <= count_d;
      low_q   <= low_d;
      kind_q  <= kind_d;
      base_q  <= base_d;
      acc_q   <= acc_d;
      idx_q   <= idx_d;
    end
  end

  // Writes come only from data records, and never beyond the pair count.
  a_write_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> kind_q == KindData)
    else $error("write produced outside a data record");

  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= pairs)
    else $error("halfword index passed the pair count");

  a_idle_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && char_i != CharColon && pos_q == PosIdle) |=> pos_q == PosIdle)
    else $error("record opened without a colon");

endmodule

>>> hdl/hrfw_out_stage.sv
// Output register with a skid stage between the parser and the result stream.
// Depends on hrfw_pkg.
module hrfw_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  hrfw_pkg::result_t in_data_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output hrfw_pkg::result_t out_data_o,
  input  logic              out_ready_i
);
  import hrfw_pkg::*;

  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  logic    out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= in_valid_i;
      end
    end else if (in_valid_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else begin
        out_q <= in_data_i;
      end
    end else if (in_valid_i) begin
      skid_q <= in_data_i;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held with an empty output register");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i |-> !skid_valid_q)
    else $error("new word arrived while the skid stage was full");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !$past(skid_valid_q)) |-> $past(out_valid_q && !out_ready_i))
    else $error("skid stage filled while the output was free");

endmodule

>>> hdl/hex_record_to_flash_writes_top.sv
// Top level of the hex record to flash write converter.
// Depends on hrfw_pkg, hrfw_parser and hrfw_out_stage.
//
// This block takes a hex record file as a stream of ASCII characters, one
// character per word on the slave side, and turns the data records into
// halfword flash writes on the master side. A colon opens a record; the byte
// count, the 16-bit address field and the record type follow, and the type is
// judged by its second digit only. A data record (type 0) loads the low 16
// address bits and then yields one write per complete byte pair, at the base
// address plus twice the pair index, with the first byte in the low half of
// the halfword; an odd trailing byte is dropped and tlast marks the final
// write of the record. An extended linear address record (type 4) loads the
// upper 16 address bits from its first two data bytes. Checksums and all other
// record types are ignored, and any character is decoded as a hex digit from
// its low bits. The base address comes out of reset as 0x0800_0000. Each
// character is decoded against the parser's field registers in the cycle it
// is accepted, and any write it produces lands on the same edge in the output
// register, or in the skid register behind it if the output register is full.
// The skid register lets the slave side keep taking one character per cycle
// while a finished write waits; the slave side only stalls once both are full.
module hex_record_to_flash_writes_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_in
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [31:0] write_address, [47:32] write_data
  output logic        m_axis_tlast_o    // last_of_record
);
  import hrfw_pkg::*;

  logic    accept;
  logic    result_valid;
  result_t result;
  result_t out_word;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  hrfw_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .char_i         (s_axis_tdata_i),
    .result_valid_o (result_valid),
    .result_o       (result)
  );

  hrfw_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (result_valid),
    .in_data_i   (result),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (out_word),
    .out_ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {out_word.write_data, out_word.write_address};
  assign m_axis_tlast_o = out_word.last_of_record;

endmodule
